>>> src/multichannel_adc_average_scale_macros.svh
// Assertion macros used by the averaging block's checker.
`ifndef MULTICHANNEL_ADC_AVERAGE_SCALE_MACROS_SVH
`define MULTICHANNEL_ADC_AVERAGE_SCALE_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define MAAS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("maas checker: property violated");

// Next-cycle implication, sampled on clock, off while reset is high.
`define MAAS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("maas checker: property violated");

`endif

>>> src/maas_pkg.sv
// Types, constants and slot codes of the multichannel ADC averaging block.
`default_nettype none
package maas_pkg;

   localparam int unsigned SAMPLE_W          = 10;
   localparam int unsigned SLOT_W            = 3;
   localparam int unsigned SCALED_W          = 9;
   localparam int unsigned NUM_SLOTS         = 6;
   localparam int unsigned AVG_SHIFT_DEFAULT = 4;

   typedef logic [SLOT_W-1:0]          slot_type;
   typedef logic [SAMPLE_W-1:0]        sample_type;
   typedef logic signed [SCALED_W-1:0] scaled_type;

   localparam slot_type SLOT_USOLAR = 3'd0;
   localparam slot_type SLOT_IBATT  = 3'd1;
   localparam slot_type SLOT_ISOLAR = 3'd2;
   localparam slot_type SLOT_USYS   = 3'd3;
   localparam slot_type SLOT_IOUT   = 3'd4;
   localparam slot_type SLOT_NTC    = 3'd5;
   localparam slot_type SLOT_LAST   = SLOT_NTC;

   // Scaling constants
   localparam int unsigned VOLT_GAIN   = 215;
   localparam int unsigned VOLT_MAX    = 255;
   localparam int unsigned CUR_OFFSET  = 511;
   localparam int unsigned CUR_GAIN    = 1000;
   localparam int unsigned SCALE_SHIFT = 10;
   localparam int          CUR_MIN     = -128;
   localparam int          CUR_MAX     = 127;

endpackage
`default_nettype wire

>>> src/multichannel_adc_average_scale.sv
// Six-slot converter sample averager: accumulator memory update and per-slot scaling.
// Takes one 10-bit sample per beat for the slot in turn (solar voltage, battery current,
// solar current, system voltage, output current, temperature, then round again) and returns
// one result beat per sample: the slot, acc >> AVG_SHIFT and a scaled value. A sample is
// accepted every cycle while the result side keeps up; its result beat goes from the accumulator
// memory's read register through the update stage that writes back to the scaling stage. The
// accumulators come up at zero straight out of reset, with no clearing pass, and the slot
// rotation restarts at solar voltage.
`default_nettype none
module multichannel_adc_average_scale #(
   parameter int unsigned AVG_SHIFT = maas_pkg::AVG_SHIFT_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire maas_pkg::sample_type req_sample,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      maas_pkg::slot_type   rsp_channel_slot,
   output      maas_pkg::sample_type rsp_averaged_value,
   output      maas_pkg::scaled_type rsp_scaled_value
);

   localparam int unsigned ACC_W = maas_pkg::SAMPLE_W + AVG_SHIFT;

   // accumulator memory and per-entry written flags
   logic [ACC_W-1:0]              acc_mem [maas_pkg::NUM_SLOTS];
   logic [maas_pkg::NUM_SLOTS-1:0] written_ff;

   maas_pkg::slot_type   slot_ff, slot_in;
   logic                 req_fire;

   // stage 1: read data back from the memory
   logic                 s1_valid_ff;
   maas_pkg::slot_type   s1_slot_ff;
   maas_pkg::sample_type s1_sample_ff;
   logic [ACC_W-1:0]     rd_data_ff;
   logic                 rd_hit_ff;
   logic                 s2_load;

   // stage 2: updated average
   logic                 s2_valid_ff;
   maas_pkg::slot_type   s2_slot_ff;
   maas_pkg::sample_type s2_avg_ff;
   logic                 out_load;

   // result stage
   logic                 out_valid_ff;
   maas_pkg::slot_type   out_slot_ff;
   maas_pkg::sample_type out_avg_ff;

   logic [ACC_W-1:0]     acc_old;
   logic [ACC_W-1:0]     acc_new;

   assign out_load  = s2_valid_ff && (!out_valid_ff || rsp_ready);
   assign s2_load   = s1_valid_ff && (!s2_valid_ff || out_load);
   assign req_ready = !s1_valid_ff || s2_load;
   assign req_fire  = req_valid && req_ready;

   assign slot_in = (slot_ff == maas_pkg::SLOT_LAST) ? maas_pkg::SLOT_USOLAR :
                    slot_ff + maas_pkg::slot_type'(1);

   always_comb begin
      acc_old = rd_hit_ff ? rd_data_ff : '0;
      acc_new = acc_old - (acc_old >> AVG_SHIFT) + ACC_W'(s1_sample_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= maas_pkg::SLOT_USOLAR;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         if (req_fire) begin
            slot_ff <= slot_in;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_load) begin
            s2_valid_ff <= 1'b1;
            written_ff[s1_slot_ff] <= 1'b1;
         end else if (out_load) begin
            s2_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Read at acceptance, write back when stage 1 advances. The rotation keeps six beats
   // between accesses to one entry, so a read never meets a pending write to it.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff   <= acc_mem[slot_ff];
         rd_hit_ff    <= written_ff[slot_ff];
         s1_slot_ff   <= slot_ff;
         s1_sample_ff <= req_sample;
      end
      if (s2_load) begin
         acc_mem[s1_slot_ff] <= acc_new;
         s2_slot_ff          <= s1_slot_ff;
         s2_avg_ff           <= acc_new[AVG_SHIFT +: maas_pkg::SAMPLE_W];
      end
      if (out_load) begin
         out_slot_ff <= s2_slot_ff;
         out_avg_ff  <= s2_avg_ff;
      end
   end

   maas_scale u_scale (
      .clock     (clock),
      .load      (out_load),
      .slot      (s2_slot_ff),
      .avg       (s2_avg_ff),
      .scaled_ff (rsp_scaled_value)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_channel_slot   = out_slot_ff;
   assign rsp_averaged_value = out_avg_ff;

endmodule
`default_nettype wire

>>> src/maas_scale.sv
// Per-slot scaling of one averaged value, registered into the result stage.
`default_nettype none
module maas_scale (
   input  wire logic                 clock,
   input  wire logic                 load,
   input  wire maas_pkg::slot_type   slot,
   input  wire maas_pkg::sample_type avg,
   output maas_pkg::scaled_type      scaled_ff
);

   localparam int unsigned VPROD_W = maas_pkg::SAMPLE_W + 8;
   localparam int unsigned DIFF_W  = maas_pkg::SAMPLE_W + 1;
   localparam int unsigned CPROD_W = DIFF_W + 10;
   localparam int unsigned QUOT_W  = CPROD_W - maas_pkg::SCALE_SHIFT;

   logic [VPROD_W-1:0]        volt_prod;
   logic [7:0]                volt_val;
   logic signed [DIFF_W-1:0]  cur_diff;
   logic signed [CPROD_W-1:0] cur_prod;
   logic signed [CPROD_W-1:0] cur_bias;
   logic signed [QUOT_W-1:0]  cur_quot;
   maas_pkg::scaled_type      cur_val;
   maas_pkg::scaled_type      scaled_in;

   always_comb begin
      volt_prod = VPROD_W'(avg) * VPROD_W'(maas_pkg::VOLT_GAIN);
      if (volt_prod[VPROD_W-1:maas_pkg::SCALE_SHIFT] > VPROD_W'(maas_pkg::VOLT_MAX)) begin
         volt_val = 8'(maas_pkg::VOLT_MAX);
      end else begin
         volt_val = volt_prod[maas_pkg::SCALE_SHIFT +: 8];
      end

      cur_diff = $signed({1'b0, avg}) - $signed(DIFF_W'(maas_pkg::CUR_OFFSET));
      cur_prod = $signed({{(CPROD_W-DIFF_W){cur_diff[DIFF_W-1]}}, cur_diff})
                 * $signed(CPROD_W'(maas_pkg::CUR_GAIN));
      // round toward zero: bias negative products before the arithmetic shift
      cur_bias = cur_prod[CPROD_W-1] ?
                 cur_prod + $signed(CPROD_W'((1 << maas_pkg::SCALE_SHIFT) - 1)) : cur_prod;
      cur_quot = QUOT_W'(cur_bias >>> maas_pkg::SCALE_SHIFT);
      if (cur_quot < $signed(QUOT_W'(maas_pkg::CUR_MIN))) begin
         cur_val = maas_pkg::scaled_type'(maas_pkg::CUR_MIN);
      end else if (cur_quot > $signed(QUOT_W'(maas_pkg::CUR_MAX))) begin
         cur_val = maas_pkg::scaled_type'(maas_pkg::CUR_MAX);
      end else begin
         cur_val = cur_quot[maas_pkg::SCALED_W-1:0];
      end

      case (slot) inside
         maas_pkg::SLOT_USOLAR, maas_pkg::SLOT_USYS: scaled_in = {1'b0, volt_val};
         maas_pkg::SLOT_IBATT, maas_pkg::SLOT_ISOLAR,
         maas_pkg::SLOT_IOUT:                        scaled_in = cur_val;
         default:                                    scaled_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         scaled_ff <= scaled_in;
      end
   end

endmodule
`default_nettype wire

>>> src/maas_checker.sv
// Port-level checks of the averaging block, bound to its top level.
`default_nettype none
`include "multichannel_adc_average_scale_macros.svh"
module maas_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire maas_pkg::slot_type   rsp_channel_slot,
   input wire maas_pkg::sample_type rsp_averaged_value,
   input wire maas_pkg::scaled_type rsp_scaled_value
);

   localparam int unsigned PAYLOAD_W =
      maas_pkg::SLOT_W + maas_pkg::SAMPLE_W + maas_pkg::SCALED_W;

   maas_pkg::slot_type     last_slot_ff;
   maas_pkg::slot_type     expect_slot;
   logic                   seen_ff;
   logic                   rsp_stall;
   logic                   rsp_volt;
   logic [PAYLOAD_W-1:0]   rsp_payload;

   assign expect_slot = (last_slot_ff == maas_pkg::SLOT_LAST) ? maas_pkg::SLOT_USOLAR :
                        last_slot_ff + maas_pkg::slot_type'(1);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_volt    = (rsp_channel_slot == maas_pkg::SLOT_USOLAR) ||
                        (rsp_channel_slot == maas_pkg::SLOT_USYS);
   assign rsp_payload = {rsp_channel_slot, rsp_averaged_value, rsp_scaled_value};

   // track the slot of the last result beat taken
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         last_slot_ff <= maas_pkg::SLOT_USOLAR;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff      <= 1'b1;
         last_slot_ff <= rsp_channel_slot;
      end
   end

   `MAAS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload))
   `MAAS_ASSERT_IMPL(a_first_slot, rsp_valid && !seen_ff, rsp_channel_slot == maas_pkg::SLOT_USOLAR)
   `MAAS_ASSERT_IMPL(a_slot_order, rsp_valid && seen_ff, rsp_channel_slot == expect_slot)
   `MAAS_ASSERT_IMPL(a_ntc_zero, rsp_valid && rsp_channel_slot == maas_pkg::SLOT_NTC, rsp_scaled_value == '0)
   `MAAS_ASSERT_IMPL(a_volt_positive, rsp_valid && rsp_volt, !rsp_scaled_value[maas_pkg::SCALED_W-1])

endmodule

bind multichannel_adc_average_scale maas_checker u_maas_checker (.*);
`default_nettype wire
